>>> rtl/ndat_pkg.sv
package ndat_pkg;

    // Field and port widths
    localparam int OFFSET_W     = 51;
    localparam int DATA_W       = 64;
    localparam int OUT_TDATA_W  = ((OFFSET_W + DATA_W + 7) / 8) * 8;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 48;
    localparam int AXIS_FIELD_W = 2;
    localparam int ELEM_BYTES_W = 4;
    localparam int NUM_DIMS_W   = 3;
    localparam int AXIS_ORDER_W = 8;

    // Parameter defaults
    localparam int MAX_DIMS_DEF      = 4;
    localparam int DIM_SIZE_BITS_DEF = 12;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ELEM_BYTES = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENCODE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_ORDER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZES  = 3'd4;

    // Register reset values
    localparam logic [NUM_DIMS_W-1:0]   NUM_DIMS_RST   = 3'd1;
    localparam logic [ELEM_BYTES_W-1:0] ELEM_BYTES_RST = 4'd1;
    localparam logic                    ENCODE_RST     = 1'b1;
    localparam logic [AXIS_ORDER_W-1:0] AXIS_ORDER_RST = 8'd228;
    localparam logic [CFG_DATA_W-1:0]   DIM_SIZES_RST  = '0;

    // Largest element size in bytes
    localparam logic [ELEM_BYTES_W-1:0] ELEM_BYTES_MAX = 4'd8;

endpackage

>>> rtl/ndat_setup.sv
module ndat_setup #(
    parameter int MAX_DIMS      = ndat_pkg::MAX_DIMS_DEF,
    parameter int DIM_SIZE_BITS = ndat_pkg::DIM_SIZE_BITS_DEF,
    parameter int IDX_W         = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1,
    parameter int ND_W          = $clog2(MAX_DIMS + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ndat_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ndat_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                busy,
    output logic [ND_W-1:0]                     n_dims,
    output logic [DIM_SIZE_BITS-1:0]            lim [MAX_DIMS],
    output logic [ndat_pkg::OFFSET_W-1:0]       delta [MAX_DIMS]
);

    typedef enum logic [2:0] {
        S_INIT,
        S_STRIDE,
        S_MAP,
        S_DMUL,
        S_DADD,
        S_DONE
    } state_t;

    localparam int OW = ndat_pkg::OFFSET_W;
    localparam int AW = ndat_pkg::AXIS_FIELD_W;

    state_t                              state_reg;
    logic [ndat_pkg::NUM_DIMS_W-1:0]     num_dims_reg;
    logic [ndat_pkg::ELEM_BYTES_W-1:0]   elem_bytes_reg;
    logic                                encode_reg;
    logic [ndat_pkg::AXIS_ORDER_W-1:0]   axis_order_reg;
    logic [ndat_pkg::CFG_DATA_W-1:0]     dim_sizes_reg;

    logic [ND_W-1:0]          n_reg;
    logic [IDX_W-1:0]         ord_reg [MAX_DIMS];
    logic [IDX_W-1:0]         k_reg;
    logic [OW-1:0]            acc_reg;
    logic [OW-1:0]            tmp_reg [MAX_DIMS];
    logic [OW-1:0]            stride_reg [MAX_DIMS];
    logic [DIM_SIZE_BITS-1:0] lim_reg [MAX_DIMS];
    logic [OW-1:0]            delta_reg [MAX_DIMS];
    logic [OW-1:0]            prod_reg;
    logic [OW-1:0]            tail_reg;

    // Clamped setup values and permutation check
    logic [ND_W-1:0]                   n_init;
    logic [ndat_pkg::ELEM_BYTES_W-1:0] eb_init;
    logic [IDX_W-1:0]                  ord_init [MAX_DIMS];
    logic                              ord_ok;
    logic [(1<<AW)-1:0]                seen;
    logic [AW-1:0]                     fld;

    always_comb
    begin
        if (num_dims_reg == '0)
            n_init = ND_W'(1);
        else if (int'(num_dims_reg) > MAX_DIMS)
            n_init = ND_W'(MAX_DIMS);
        else
            n_init = ND_W'(num_dims_reg);

        if (elem_bytes_reg == '0)
            eb_init = ndat_pkg::ELEM_BYTES_W'(1);
        else if (elem_bytes_reg > ndat_pkg::ELEM_BYTES_MAX)
            eb_init = ndat_pkg::ELEM_BYTES_MAX;
        else
            eb_init = elem_bytes_reg;

        ord_ok = 1'b1;
        seen   = '0;
        fld    = '0;
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            fld = axis_order_reg[d*AW +: AW];
            if (d < int'(n_init))
            begin
                if (int'(fld) >= int'(n_init) || seen[fld])
                    ord_ok = 1'b0;
                seen[fld] = 1'b1;
            end
        end
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            if (ord_ok && d < int'(n_init))
                ord_init[d] = IDX_W'(axis_order_reg[d*AW +: AW]);
            else
                ord_init[d] = IDX_W'(d);
        end
    end

    // Axis touched by the current stride step and its size
    logic [IDX_W-1:0]         axis_sel;
    logic [DIM_SIZE_BITS:0]   size_sel;
    logic                     k_active;

    always_comb
    begin
        axis_sel = encode_reg ? ord_reg[k_reg] : k_reg;
        size_sel = {1'b0, dim_sizes_reg[axis_sel*DIM_SIZE_BITS +: DIM_SIZE_BITS]} +
                   (DIM_SIZE_BITS+1)'(1);
        k_active = ND_W'(k_reg) < n_reg;
    end

    logic cfg_hit;
    assign cfg_hit   = cfg_valid && (cfg_index <= ndat_pkg::REG_DIM_SIZES);
    assign cfg_ready = 1'b1;

    // Register file and setup sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            num_dims_reg   <= ndat_pkg::NUM_DIMS_RST;
            elem_bytes_reg <= ndat_pkg::ELEM_BYTES_RST;
            encode_reg     <= ndat_pkg::ENCODE_RST;
            axis_order_reg <= ndat_pkg::AXIS_ORDER_RST;
            dim_sizes_reg  <= ndat_pkg::DIM_SIZES_RST;
            n_reg          <= ND_W'(1);
            k_reg          <= '0;
            acc_reg        <= '0;
            prod_reg       <= '0;
            tail_reg       <= '0;
            for (int d = 0; d < MAX_DIMS; d++)
            begin
                ord_reg[d]    <= IDX_W'(d);
                tmp_reg[d]    <= '0;
                stride_reg[d] <= '0;
                lim_reg[d]    <= '0;
                delta_reg[d]  <= '0;
            end
        end
        else if (cfg_hit)
        begin
            // any register write restarts the stride computation
            case (cfg_index)
                ndat_pkg::REG_NUM_DIMS:
                    num_dims_reg <= cfg_data[ndat_pkg::NUM_DIMS_W-1:0];
                ndat_pkg::REG_ELEM_BYTES:
                    elem_bytes_reg <= cfg_data[ndat_pkg::ELEM_BYTES_W-1:0];
                ndat_pkg::REG_ENCODE:
                    encode_reg <= cfg_data[0];
                ndat_pkg::REG_AXIS_ORDER:
                    axis_order_reg <= cfg_data[ndat_pkg::AXIS_ORDER_W-1:0];
                ndat_pkg::REG_DIM_SIZES:
                    dim_sizes_reg <= cfg_data;
                default:
                    dim_sizes_reg <= dim_sizes_reg;
            endcase
            state_reg <= S_INIT;
        end
        else
        begin
            case (state_reg)
                S_INIT:
                begin
                    n_reg   <= n_init;
                    acc_reg <= OW'(eb_init);
                    k_reg   <= IDX_W'(MAX_DIMS - 1);
                    for (int d = 0; d < MAX_DIMS; d++)
                    begin
                        ord_reg[d] <= ord_init[d];
                        tmp_reg[d] <= '0;
                    end
                    state_reg <= S_STRIDE;
                end
                // one running product per cycle, last axis first
                S_STRIDE:
                begin
                    if (k_active)
                    begin
                        tmp_reg[axis_sel] <= acc_reg;
                        acc_reg           <= acc_reg * OW'(size_sel);
                    end
                    if (k_reg == '0)
                        state_reg <= S_MAP;
                    else
                        k_reg <= k_reg - IDX_W'(1);
                end
                // strides and limits per counting axis
                S_MAP:
                begin
                    for (int j = 0; j < MAX_DIMS; j++)
                    begin
                        if (j < int'(n_reg))
                        begin
                            stride_reg[j] <= encode_reg ? tmp_reg[j] : tmp_reg[ord_reg[j]];
                            lim_reg[j]    <= encode_reg ?
                                dim_sizes_reg[j*DIM_SIZE_BITS +: DIM_SIZE_BITS] :
                                dim_sizes_reg[ord_reg[j]*DIM_SIZE_BITS +: DIM_SIZE_BITS];
                        end
                        else
                        begin
                            stride_reg[j] <= '0;
                            lim_reg[j]    <= '0;
                        end
                    end
                    tail_reg  <= '0;
                    k_reg     <= IDX_W'(MAX_DIMS - 1);
                    state_reg <= S_DMUL;
                end
                // step offset for a carry into axis k: its stride less the
                // span of every faster axis wrapping back to zero
                S_DMUL:
                begin
                    delta_reg[k_reg] <= stride_reg[k_reg] - tail_reg;
                    prod_reg         <= stride_reg[k_reg] * OW'(lim_reg[k_reg]);
                    state_reg        <= S_DADD;
                end
                S_DADD:
                begin
                    tail_reg <= tail_reg + prod_reg;
                    if (k_reg == '0)
                        state_reg <= S_DONE;
                    else
                    begin
                        k_reg     <= k_reg - IDX_W'(1);
                        state_reg <= S_DMUL;
                    end
                end
                S_DONE:
                    state_reg <= S_DONE;
                default:
                    state_reg <= S_INIT;
            endcase
        end
    end

    assign busy   = (state_reg != S_DONE);
    assign n_dims = n_reg;
    assign lim    = lim_reg;
    assign delta  = delta_reg;

endmodule

>>> rtl/ndat_walk.sv
module ndat_walk #(
    parameter int MAX_DIMS      = ndat_pkg::MAX_DIMS_DEF,
    parameter int DIM_SIZE_BITS = ndat_pkg::DIM_SIZE_BITS_DEF,
    parameter int ND_W          = $clog2(MAX_DIMS + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                busy,
    input  logic [ND_W-1:0]                     n_dims,
    input  logic [DIM_SIZE_BITS-1:0]            lim [MAX_DIMS],
    input  logic [ndat_pkg::OFFSET_W-1:0]       delta [MAX_DIMS],
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ndat_pkg::DATA_W-1:0]         s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ndat_pkg::OFFSET_W-1:0]       m_offset,
    output logic [ndat_pkg::DATA_W-1:0]         m_data,
    output logic                                m_last
);

    localparam int OW = ndat_pkg::OFFSET_W;

    logic [DIM_SIZE_BITS-1:0] cnt_reg [MAX_DIMS];
    logic [DIM_SIZE_BITS-1:0] cnt_next [MAX_DIMS];
    logic [OW-1:0]            offset_reg;
    logic [OW-1:0]            offset_next;
    logic                     out_valid_reg;
    logic [OW-1:0]            out_offset_reg;
    logic [ndat_pkg::DATA_W-1:0] out_data_reg;
    logic                     out_last_reg;

    logic [MAX_DIMS-1:0] at_lim;
    logic [MAX_DIMS-1:0] above;
    logic                last;
    logic [OW-1:0]       delta_sel;
    logic                accept;

    // Odometer: the fastest active axis that is not at its limit steps,
    // every faster axis wraps to zero
    always_comb
    begin
        for (int d = 0; d < MAX_DIMS; d++)
            at_lim[d] = (d >= int'(n_dims)) || (cnt_reg[d] == lim[d]);

        above[MAX_DIMS-1] = 1'b1;
        for (int d = MAX_DIMS - 2; d >= 0; d--)
            above[d] = above[d+1] && at_lim[d+1];

        last      = &at_lim;
        delta_sel = '0;
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            if (above[d] && !at_lim[d])
            begin
                cnt_next[d] = cnt_reg[d] + DIM_SIZE_BITS'(1);
                delta_sel   = delta[d];
            end
            else if (above[d])
                cnt_next[d] = '0;
            else
                cnt_next[d] = cnt_reg[d];
        end
        offset_next = last ? '0 : offset_reg + delta_sel;
    end

    assign s_tready = !busy && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    // Position state, cleared while strides are being set up
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            for (int d = 0; d < MAX_DIMS; d++)
                cnt_reg[d] <= '0;
        end
        else if (busy)
        begin
            offset_reg <= '0;
            for (int d = 0; d < MAX_DIMS; d++)
                cnt_reg[d] <= '0;
        end
        else if (accept)
        begin
            offset_reg <= offset_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_offset_reg <= offset_reg;
            out_data_reg   <= s_tdata;
            out_last_reg   <= last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_offset = out_offset_reg;
    assign m_data   = out_data_reg;
    assign m_last   = out_last_reg;

endmodule

>>> rtl/ndarray_axis_transpose_addressing.sv
// Transpose address generator for one N-dimensional chunk: each element beat
// on the slave stream comes out on the master stream with its byte offset in
// the destination buffer, its data unchanged, and tlast on the final element
// of the chunk, after which the next chunk starts with the same setup. One
// element is taken every clock cycle while setup is done and the output is not
// stalled, and the output beat is registered; the rate is set by the per-axis
// position counters and one 51-bit add of a precomputed step. After reset and
// after any register write the block works out strides with two narrow
// multipliers, and holds s_tready low while it does so.
module ndarray_axis_transpose_addressing #(
    parameter int MAX_DIMS      = ndat_pkg::MAX_DIMS_DEF,
    parameter int DIM_SIZE_BITS = ndat_pkg::DIM_SIZE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // config write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ndat_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ndat_pkg::CFG_DATA_W-1:0]     cfg_data,
    // element stream in
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ndat_pkg::DATA_W-1:0]         s_tdata,   // elem_data
    // element stream out
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ndat_pkg::OUT_TDATA_W-1:0]    m_tdata,   // dest_offset, out_data, zero pad
    output logic                                m_tlast    // last_elem
);

    localparam int ND_W = $clog2(MAX_DIMS + 1);

    logic                          busy;
    logic [ND_W-1:0]               n_dims;
    logic [DIM_SIZE_BITS-1:0]      lim [MAX_DIMS];
    logic [ndat_pkg::OFFSET_W-1:0] delta [MAX_DIMS];
    logic [ndat_pkg::OFFSET_W-1:0] m_offset;
    logic [ndat_pkg::DATA_W-1:0]   m_data;

    ndat_setup #(
        .MAX_DIMS      (MAX_DIMS),
        .DIM_SIZE_BITS (DIM_SIZE_BITS)
    ) u_setup (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .busy      (busy),
        .n_dims    (n_dims),
        .lim       (lim),
        .delta     (delta)
    );

    ndat_walk #(
        .MAX_DIMS      (MAX_DIMS),
        .DIM_SIZE_BITS (DIM_SIZE_BITS)
    ) u_walk (
        .clk      (clk),
        .rst_n    (rst_n),
        .busy     (busy),
        .n_dims   (n_dims),
        .lim      (lim),
        .delta    (delta),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_offset (m_offset),
        .m_data   (m_data),
        .m_last   (m_tlast)
    );

    // pack output beat, offset in the low bits
    assign m_tdata = {{(ndat_pkg::OUT_TDATA_W - ndat_pkg::OFFSET_W - ndat_pkg::DATA_W){1'b0}},
                      m_data, m_offset};

endmodule

>>> verif/ndarray_axis_transpose_addressing_tb.sv
module ndarray_axis_transpose_addressing_tb;

    localparam int OFFSET_W     = ndat_pkg::OFFSET_W;
    localparam int DATA_W       = ndat_pkg::DATA_W;
    localparam int OUT_TDATA_W  = ndat_pkg::OUT_TDATA_W;
    localparam int CFG_IDX_W    = ndat_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W   = ndat_pkg::CFG_DATA_W;
    localparam int NUM_DIMS_W   = ndat_pkg::NUM_DIMS_W;
    localparam int ELEM_BYTES_W = ndat_pkg::ELEM_BYTES_W;
    localparam int AXIS_ORDER_W = ndat_pkg::AXIS_ORDER_W;

    localparam int AXES        = ndat_pkg::MAX_DIMS_DEF;
    localparam int SZ_BITS     = ndat_pkg::DIM_SIZE_BITS_DEF;
    localparam int STALL_LIMIT = 4000;
    localparam int ELEM_TARGET = 1900;

    // indexes past the register list: writes there are ignored
    localparam logic [CFG_IDX_W-1:0] REG_PAST_END = ndat_pkg::REG_DIM_SIZES + 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_IDX  = 3'd7;

    typedef struct {
        logic [OFFSET_W-1:0] offset;
        logic [DATA_W-1:0]   data;
        logic                last;
    } dest_beat_t;

    // one pending stimulus entry: an element beat or a register write
    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
        logic [DATA_W-1:0]     data;
        int                    phase;
    } feed_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [DATA_W-1:0]      s_tdata = '0;       // elem_data
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;            // dest_offset, out_data, zero pad
    logic                   m_tlast;            // last_elem

    ndarray_axis_transpose_addressing u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    feed_t      feed_q[$];
    dest_beat_t dest_q[$];
    int         recv_pct = 66;
    int         miss_cnt = 0;
    int         stall_cycles = 0;
    int         cur_phase = 0;
    int         n_elems = 0;

    // address generator shadow: registers, odometer, strides
    logic [NUM_DIMS_W-1:0]   r_ndims;
    logic [ELEM_BYTES_W-1:0] r_ebytes;
    logic                    r_encode;
    logic [AXIS_ORDER_W-1:0] r_order;
    logic [CFG_DATA_W-1:0]   r_sizes_m1;
    logic [SZ_BITS-1:0]      pos_cnt [AXES];
    logic [SZ_BITS-1:0]      pos_lim [AXES];
    logic [OFFSET_W-1:0]     stride [AXES];
    logic [OFFSET_W-1:0]     next_offset;
    int                      used_dims;

    // Recompute strides and limits, restart the chunk
    function automatic void reset_walk();
        int          n;
        int          eb;
        int          v;
        bit          ok;
        logic [3:0]  seen;
        logic [63:0] acc;
        int          ord [AXES];
        logic [63:0] sz [AXES];
        logic [63:0] ostr [AXES];
        n = int'(r_ndims);
        if (n < 1) n = 1;
        if (n > AXES) n = AXES;
        eb = int'(r_ebytes);
        if (eb < 1) eb = 1;
        if (eb > int'(ndat_pkg::ELEM_BYTES_MAX)) eb = int'(ndat_pkg::ELEM_BYTES_MAX);
        used_dims = n;
        ok = 1'b1;
        seen = '0;
        for (int d = 0; d < AXES; d++)
        begin
            v = int'(r_order[2*d +: 2]);
            ord[d] = d;
            sz[d] = 64'(r_sizes_m1[d*SZ_BITS +: SZ_BITS]) + 64'd1;
            ostr[d] = '0;
            if (d < n)
            begin
                if (v >= n || seen[v]) ok = 1'b0;
                seen[v] = 1'b1;
                ord[d] = v;
            end
            pos_cnt[d] = '0;
            pos_lim[d] = '0;
            stride[d] = '0;
        end
        // not a permutation: fall back to identity
        if (!ok)
            for (int d = 0; d < AXES; d++) ord[d] = d;
        acc = 64'(eb);
        if (r_encode)
        begin
            for (int d = 0; d < n; d++) pos_lim[d] = SZ_BITS'(sz[d] - 64'd1);
            for (int d = n - 1; d >= 0; d--)
            begin
                stride[ord[d]] = acc[OFFSET_W-1:0];
                acc = acc * sz[ord[d]];
            end
        end
        else
        begin
            for (int d = 0; d < n; d++) pos_lim[d] = SZ_BITS'(sz[ord[d]] - 64'd1);
            for (int d = n - 1; d >= 0; d--)
            begin
                ostr[d] = acc;
                acc = acc * sz[d];
            end
            for (int d = 0; d < n; d++) stride[d] = ostr[ord[d]][OFFSET_W-1:0];
        end
        next_offset = '0;
    endfunction

    function automatic void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        bit hit;
        hit = 1'b1;
        case (idx)
            ndat_pkg::REG_NUM_DIMS:   r_ndims = val[NUM_DIMS_W-1:0];
            ndat_pkg::REG_ELEM_BYTES: r_ebytes = val[ELEM_BYTES_W-1:0];
            ndat_pkg::REG_ENCODE:     r_encode = val[0];
            ndat_pkg::REG_AXIS_ORDER: r_order = val[AXIS_ORDER_W-1:0];
            ndat_pkg::REG_DIM_SIZES:  r_sizes_m1 = val;
            default:                  hit = 1'b0;
        endcase
        if (hit) reset_walk();
    endfunction

    // Offset of this element, then step the odometer (last axis fastest)
    function automatic dest_beat_t place_element(logic [DATA_W-1:0] data);
        dest_beat_t  b;
        bit          carry;
        logic [63:0] sum;
        b.offset = next_offset;
        b.data = data;
        b.last = 1'b1;
        for (int d = 0; d < used_dims; d++)
            if (pos_cnt[d] != pos_lim[d]) b.last = 1'b0;
        carry = 1'b1;
        for (int d = used_dims - 1; d >= 0; d--)
        begin
            if (carry)
            begin
                if (pos_cnt[d] < pos_lim[d])
                begin
                    pos_cnt[d] = pos_cnt[d] + SZ_BITS'(1);
                    carry = 1'b0;
                end
                else
                    pos_cnt[d] = '0;
            end
        end
        sum = '0;
        for (int d = 0; d < used_dims; d++) sum = sum + 64'(pos_cnt[d]) * 64'(stride[d]);
        next_offset = sum[OFFSET_W-1:0];
        return b;
    endfunction

    function automatic int idle_pct(int ph, bit rx);
        case (ph)
            0:       return rx ? 66 : 35;
            1:       return rx ? 35 : 66;
            default: return 0;
        endcase
    endfunction

    function automatic void note_miss(string what, logic [63:0] want, logic [63:0] got);
        if (miss_cnt < 10)
            $display("mismatch %s: expected %h, got %h", what, want, got);
        miss_cnt++;
    endfunction

    function automatic void push_elem(logic [DATA_W-1:0] data);
        feed_t f;
        f.is_cfg = 1'b0;
        f.idx = '0;
        f.val = '0;
        f.data = data;
        f.phase = cur_phase;
        feed_q = {feed_q, f};
        n_elems++;
    endfunction

    function automatic void push_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        feed_t f;
        f.is_cfg = 1'b1;
        f.idx = idx;
        f.val = val;
        f.data = '0;
        f.phase = cur_phase;
        feed_q = {feed_q, f};
    endfunction

    function automatic logic [DATA_W-1:0] rand_data();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Driver: element beats and register writes from the feed queue
    always @(posedge clk)
    begin : drive
        feed_t                 nx;
        dest_beat_t            nb;
        logic                  s_busy;
        logic                  c_busy;
        logic                  nv_s;
        logic                  nv_c;
        logic [DATA_W-1:0]     nd_s;
        logic [CFG_IDX_W-1:0]  ni_c;
        logic [CFG_DATA_W-1:0] nd_c;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                nb = place_element(s_tdata);
                dest_q = {dest_q, nb};
            end
            if (cfg_valid && cfg_ready) write_reg(cfg_index, cfg_data);
            s_busy = s_tvalid && !s_tready;
            c_busy = cfg_valid && !cfg_ready;
            nv_s = s_busy;
            nv_c = c_busy;
            nd_s = s_tdata;
            ni_c = cfg_index;
            nd_c = cfg_data;
            if (!s_busy && !c_busy && feed_q.size() > 0)
            begin
                nx = feed_q[0];
                if (nx.is_cfg)
                begin
                    // registers change only once every result is out
                    if (dest_q.size() == 0)
                    begin
                        nv_c = 1'b1;
                        ni_c = nx.idx;
                        nd_c = nx.val;
                        void'(feed_q.pop_front());
                    end
                end
                else if ($urandom_range(99) >= idle_pct(nx.phase, 1'b0))
                begin
                    nv_s = 1'b1;
                    nd_s = nx.data;
                    recv_pct <= idle_pct(nx.phase, 1'b1);
                    void'(feed_q.pop_front());
                end
            end
            s_tvalid <= nv_s;
            s_tdata <= nd_s;
            cfg_valid <= nv_c;
            cfg_index <= ni_c;
            cfg_data <= nd_c;
        end
    end

    // Monitor: check each output beat against the oldest expected one
    always @(posedge clk)
    begin : watch_out
        dest_beat_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (dest_q.size() == 0)
                    note_miss("unexpected beat", '0, 64'(m_tdata[OFFSET_W-1:0]));
                else
                begin
                    want = dest_q.pop_front();
                    if (m_tdata[OFFSET_W-1:0] !== want.offset)
                        note_miss("dest_offset", 64'(want.offset), 64'(m_tdata[OFFSET_W-1:0]));
                    if (m_tdata[OFFSET_W +: DATA_W] !== want.data)
                        note_miss("out_data", want.data, m_tdata[OFFSET_W +: DATA_W]);
                    if (m_tlast !== want.last)
                        note_miss("last_elem", 64'(want.last), 64'(m_tlast));
                    if (m_tdata[OUT_TDATA_W-1:OFFSET_W+DATA_W] !== '0)
                        note_miss("tdata pad", '0,
                                  64'(m_tdata[OUT_TDATA_W-1:OFFSET_W+DATA_W]));
                end
            end
            m_tready <= ($urandom_range(99) >= recv_pct);
        end
    end

    // Watchdog on cycles with no beat accepted anywhere
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("ndarray_axis_transpose_addressing_tb NOT OK");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin : stimulus
        int          g_nd;
        int          g_sizes [AXES];
        int          eff_n;
        int          cnt;
        int          brk;
        int          j;
        int          t;
        int          p [AXES];
        logic [63:0] vol;
        logic [7:0]  ord;
        logic [47:0] sizes;

        // shadow at reset state
        r_ndims = ndat_pkg::NUM_DIMS_RST;
        r_ebytes = ndat_pkg::ELEM_BYTES_RST;
        r_encode = ndat_pkg::ENCODE_RST;
        r_order = ndat_pkg::AXIS_ORDER_RST;
        r_sizes_m1 = ndat_pkg::DIM_SIZES_RST;
        reset_walk();

        // Directed: reset setup, single-element chunks
        push_elem('0);
        push_elem('1);
        // zero dimension count and oversized element, 3-long chunk; ignored write mid-chunk
        push_reg(ndat_pkg::REG_NUM_DIMS, 48'h0);
        push_reg(ndat_pkg::REG_ELEM_BYTES, 48'hF);
        push_reg(ndat_pkg::REG_DIM_SIZES, 48'h2);
        push_elem(rand_data());
        push_elem(rand_data());
        push_reg(REG_PAST_END, 48'({$urandom, $urandom}));
        push_elem(rand_data());
        push_elem(rand_data());
        // four axes (from oversized count), zero element size, reversed order
        push_reg(ndat_pkg::REG_NUM_DIMS, 48'hFFFF_FFFF_FFFF);
        push_reg(ndat_pkg::REG_ELEM_BYTES, 48'hFFFF_FFFF_FFF0);
        push_reg(ndat_pkg::REG_AXIS_ORDER, 48'h1B);
        push_reg(ndat_pkg::REG_DIM_SIZES, 48'h001001000001);
        for (int i = 0; i < 5; i++) push_elem(rand_data());
        // switch to decode mid-chunk: restart, run a whole chunk
        push_reg(ndat_pkg::REG_ENCODE, 48'h0);
        for (int i = 0; i < 8; i++) push_elem(rand_data());
        // duplicate axes in the order: identity used
        push_reg(ndat_pkg::REG_AXIS_ORDER, 48'h05);
        for (int i = 0; i < 3; i++) push_elem(rand_data());
        // largest sizes and element width
        push_reg(ndat_pkg::REG_DIM_SIZES, 48'hFFFF_FFFF_FFFF);
        push_reg(ndat_pkg::REG_ELEM_BYTES, 48'h8);
        push_reg(ndat_pkg::REG_ENCODE, 48'hFFFF_FFFF_FFFF);
        push_reg(ndat_pkg::REG_AXIS_ORDER, 48'h1B);
        push_reg(REG_TOP_IDX, 48'({$urandom, $urandom}));
        for (int i = 0; i < 3; i++) push_elem(rand_data());

        g_nd = AXES;
        g_sizes = '{0: 4095, 1: 4095, 2: 4095, 3: 4095};

        // Random setups, each followed by a run of elements
        while (n_elems < ELEM_TARGET)
        begin
            cur_phase = n_elems * 3 / ELEM_TARGET;
            if (cur_phase > 2) cur_phase = 2;
            cnt = 0;
            while (cnt == 0)
            begin
                if ($urandom_range(99) < 60)
                begin
                    g_nd = ($urandom_range(7) == 0) ? $urandom_range(7) : $urandom_range(1, AXES);
                    push_reg(ndat_pkg::REG_NUM_DIMS,
                             48'({$urandom, $urandom}) & ~48'h7 | 48'(g_nd));
                    cnt++;
                end
                if ($urandom_range(99) < 50)
                begin
                    t = ($urandom_range(7) == 0) ? $urandom_range(15) : $urandom_range(1, 8);
                    push_reg(ndat_pkg::REG_ELEM_BYTES,
                             48'({$urandom, $urandom}) & ~48'hF | 48'(t));
                    cnt++;
                end
                if ($urandom_range(99) < 50)
                begin
                    push_reg(ndat_pkg::REG_ENCODE, 48'({$urandom, $urandom}));
                    cnt++;
                end
                if ($urandom_range(99) < 60)
                begin
                    eff_n = (g_nd < 1) ? 1 : (g_nd > AXES) ? AXES : g_nd;
                    ord = 8'($urandom);
                    if ($urandom_range(3) != 0)
                    begin
                        for (int i = 0; i < AXES; i++) p[i] = i;
                        for (int i = eff_n - 1; i > 0; i--)
                        begin
                            j = $urandom_range(i);
                            t = p[i];
                            p[i] = p[j];
                            p[j] = t;
                        end
                        for (int i = 0; i < eff_n; i++) ord[2*i +: 2] = 2'(p[i]);
                    end
                    push_reg(ndat_pkg::REG_AXIS_ORDER,
                             48'({$urandom, $urandom}) & ~48'hFF | 48'(ord));
                    cnt++;
                end
                if ($urandom_range(99) < 60)
                begin
                    for (int i = 0; i < AXES; i++)
                    begin
                        t = $urandom_range(99);
                        if (t < 70) g_sizes[i] = $urandom_range(3);
                        else if (t < 95) g_sizes[i] = $urandom_range(15);
                        else if (t < 97) g_sizes[i] = 4095;
                        else g_sizes[i] = $urandom_range(4095);
                        sizes[i*SZ_BITS +: SZ_BITS] = SZ_BITS'(g_sizes[i]);
                    end
                    push_reg(ndat_pkg::REG_DIM_SIZES, sizes);
                    cnt++;
                end
            end

            // chunk volume decides how many elements to send
            eff_n = (g_nd < 1) ? 1 : (g_nd > AXES) ? AXES : g_nd;
            vol = 64'd1;
            for (int i = 0; i < eff_n; i++) vol = vol * 64'(g_sizes[i] + 1);
            if (vol <= 48)
                cnt = int'(vol) * $urandom_range(1, 3) + $urandom_range(0, int'(vol) - 1);
            else
                cnt = $urandom_range(4, 48);
            brk = ($urandom_range(5) == 0) ? $urandom_range(1, cnt) : -1;
            for (int i = 0; i < cnt; i++)
            begin
                if (i == brk)
                    push_reg(REG_PAST_END + CFG_IDX_W'($urandom_range(2)),
                             48'({$urandom, $urandom}));
                push_elem(rand_data());
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // drain, then allow the registered output to settle
        while (feed_q.size() != 0 || s_tvalid || cfg_valid || dest_q.size() != 0)
            @(negedge clk);
        repeat (16) @(posedge clk);
        if (miss_cnt == 0)
            $display("ndarray_axis_transpose_addressing_tb OK");
        else
            $display("ndarray_axis_transpose_addressing_tb NOT OK");
        $finish;
    end

endmodule
